FILE: hw/rtl/hnb_pkg.sv
// Package: types and constants of the heightmap normalize/sample core.
package hnb_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 17;
  localparam int RAW_W    = 16;
  localparam int WORLD_W  = 32;
  localparam int HEIGHT_W = 26;
  localparam int STATUS_W = 2;
  localparam int RES_W    = 4;
  localparam int CELL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Divider: 42-bit dividend, 16-bit divisor, one bit per cycle.
  localparam int DIV_W     = 42;
  localparam int DIV_CNT_W = 6;
  localparam int SUM_W     = 34;
  localparam int ACC_W     = 32;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 17;
  localparam int WGT_W     = 9;
  localparam int FIN_W     = 44;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RES_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd1;

  localparam logic [RES_W-1:0]  RES_RESET  = 4'd8;
  localparam logic [RES_W-1:0]  RES_MIN    = 4'd4;
  localparam logic [CELL_W-1:0] CELL_RESET = 16'd512;

  localparam logic [RAW_W-1:0] RAW_MIN_RESET = 16'hFFFF;
  localparam logic [RAW_W-1:0] RAW_MAX_RESET = 16'h0000;

  localparam logic signed [FIN_W-1:0] HEIGHT_OFFSET = 44'sd5898240;
  localparam logic signed [FIN_W-1:0] HEIGHT_LOW    = -44'sd5898240;
  localparam logic signed [FIN_W-1:0] HEIGHT_HIGH   = 44'sd17694720;
  localparam logic [MUL_B_W-1:0]      SCALE_360     = 17'd360;
  localparam logic [WGT_W-1:0]        WGT_ONE       = 9'd256;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        sample_index;
    logic [RAW_W-1:0]          raw_sample;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [STATUS_W-1:0]        status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_LDZ, S_DIVZ, S_CAPZ, S_RDA, S_MACB,
    S_NORM, S_DIVN, S_FIN, S_DONE
  } state_e;

endpackage

FILE: hw/rtl/hnb_in_if.sv
// Input item channel.
interface hnb_in_if;
  logic              valid;
  logic              ready;
  hnb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/hnb_out_if.sv
// Result item channel.
interface hnb_out_if;
  logic               valid;
  logic               ready;
  hnb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/hnb_cfg_if.sv
// Configuration write channel.
interface hnb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hnb_pkg::CFG_IDX_W-1:0]     index;
  logic [hnb_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/heightmap_normalize_bilinear_sample_core.sv
// Heightmap store with normalized bilinear height query, shared divider and multiplier.
// Clear, write and unused func: accept, then S_DONE until the result register is free, then next item.
// Query: the 1-bit-per-cycle divider runs three times (x position, z position, normalization),
// each corner takes S_RDA and S_MACB, and 5 control steps: S_LDZ, S_CAPZ, S_NORM, S_FIN, S_DONE.
// Empty-range query: straight to S_DONE. One item at a time; a result may wait in the output register.
// Reset (async, active low): range cleared, registers at defaults; store contents undefined.
module heightmap_normalize_bilinear_sample_core #(
  parameter int MAX_RES_LOG2 = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hnb_in_if.sink     in_i,
  hnb_out_if.source  out_o,
  hnb_cfg_if.sink    cfg_i
);

  localparam int SIDE_MAX = (1 << MAX_RES_LOG2) + 1;
  localparam int DEPTH    = SIDE_MAX * SIDE_MAX;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CRD_W    = MAX_RES_LOG2 + 1;
  localparam int POS_W    = MAX_RES_LOG2 + 9;
  localparam int CMP_W    = (2 * MAX_RES_LOG2 + 2 > hnb_pkg::INDEX_W) ?
                            2 * MAX_RES_LOG2 + 2 : hnb_pkg::INDEX_W;
  localparam logic [hnb_pkg::RES_W-1:0] RES_MAX = hnb_pkg::RES_W'(MAX_RES_LOG2);

  hnb_pkg::state_e state_q, state_d;

  logic [hnb_pkg::RES_W-1:0]  res_q;
  logic [hnb_pkg::CELL_W-1:0] cell_q;
  logic [hnb_pkg::RAW_W-1:0]  min_q, max_q;

  logic signed [hnb_pkg::WORLD_W-1:0] wz_q;
  logic [hnb_pkg::DIV_W-1:0]     quo_q;
  logic [hnb_pkg::CELL_W:0]      rem_q;
  logic [hnb_pkg::CELL_W-1:0]    div_q;
  logic [hnb_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [POS_W-1:0]              gx_q, gz_q;
  logic [1:0]                    corner_q;
  logic [hnb_pkg::MUL_B_W-1:0]   w_q;
  logic [hnb_pkg::ACC_W-1:0]     acc_q;
  logic                          neg_q;
  logic [hnb_pkg::RAW_W-1:0]     rdata_q;
  logic signed [hnb_pkg::HEIGHT_W-1:0] res_height_q;
  logic [hnb_pkg::STATUS_W-1:0]  res_status_q;
  logic                          out_valid_q;
  hnb_pkg::out_item_t            out_data_q;

  logic [hnb_pkg::RAW_W-1:0] mem [DEPTH];

  logic in_acc, load_out, in_ready;
  logic [hnb_pkg::RES_W-1:0]  r_eff;
  logic [CRD_W-1:0]           last;
  logic [POS_W-1:0]           lim;
  logic [hnb_pkg::CELL_W-1:0] cell_eff;
  logic [hnb_pkg::SUM_W-1:0]  half;
  logic [CMP_W-1:0]           side_sq, idx_ext;
  logic                       idx_ok;

  assign r_eff = (res_q < hnb_pkg::RES_MIN) ? hnb_pkg::RES_MIN :
                 (res_q > RES_MAX) ? RES_MAX : res_q;
  assign last = CRD_W'(1) << r_eff;
  assign lim = {last, 8'd0};
  assign cell_eff = (cell_q == '0) ? hnb_pkg::CELL_W'(1) : cell_q;
  assign half = hnb_pkg::SUM_W'(cell_eff) << (r_eff - 4'd1);
  assign side_sq = (CMP_W'(1) << {r_eff, 1'b0}) + (CMP_W'(1) << (r_eff + 4'd1)) + CMP_W'(1);
  assign idx_ext = CMP_W'(in_i.data.sample_index);
  assign idx_ok = idx_ext < side_sq;

  // Dividend from a world coordinate: (w + half) * 256, zero when negative.
  function automatic logic [hnb_pkg::DIV_W-1:0] pos_dividend(
    input logic signed [hnb_pkg::WORLD_W-1:0] w,
    input logic [hnb_pkg::SUM_W-1:0] h
  );
    logic [hnb_pkg::SUM_W-1:0] s;
    s = hnb_pkg::SUM_W'(w) + h;
    if (s[hnb_pkg::SUM_W-1]) pos_dividend = '0;
    else pos_dividend = hnb_pkg::DIV_W'({s[hnb_pkg::SUM_W-2:0], 8'd0});
  endfunction

  // Divider step.
  logic [hnb_pkg::CELL_W+1:0] rem_sh;
  logic                       qbit;
  logic [hnb_pkg::CELL_W:0]   rem_nx;
  assign rem_sh = {rem_q, quo_q[hnb_pkg::DIV_W-1]};
  assign qbit = rem_sh >= {2'b0, div_q};
  assign rem_nx = qbit ? (hnb_pkg::CELL_W+1)'(rem_sh - {2'b0, div_q}) :
                  rem_sh[hnb_pkg::CELL_W:0];

  logic [POS_W-1:0] quo_clamped;
  assign quo_clamped = (quo_q > hnb_pkg::DIV_W'(lim)) ? lim : quo_q[POS_W-1:0];

  // Corner coordinates and weights.
  logic [CRD_W-1:0] x0, z0, x1, z1, xs, zs;
  logic [7:0]       tx, tz;
  logic [hnb_pkg::WGT_W-1:0] wx, wz;
  logic [ADDR_W-1:0] rd_addr, mem_addr;
  assign x0 = gx_q[POS_W-1:8];
  assign z0 = gz_q[POS_W-1:8];
  assign tx = gx_q[7:0];
  assign tz = gz_q[7:0];
  assign x1 = (x0 >= last) ? last : x0 + CRD_W'(1);
  assign z1 = (z0 >= last) ? last : z0 + CRD_W'(1);
  assign xs = corner_q[0] ? x1 : x0;
  assign zs = corner_q[1] ? z1 : z0;
  assign wx = corner_q[0] ? {1'b0, tx} : hnb_pkg::WGT_ONE - {1'b0, tx};
  assign wz = corner_q[1] ? {1'b0, tz} : hnb_pkg::WGT_ONE - {1'b0, tz};
  assign rd_addr = (ADDR_W'(zs) << r_eff) + ADDR_W'(zs) + ADDR_W'(xs);

  logic mem_we;
  assign mem_we = in_acc && (in_i.data.func == hnb_pkg::FUNC_WRITE) && idx_ok;
  assign mem_addr = (state_q == hnb_pkg::S_IDLE) ? idx_ext[ADDR_W-1:0] : rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= in_i.data.raw_sample;
    end
    rdata_q <= mem[mem_addr];
  end

  // Normalization terms.
  logic signed [hnb_pkg::SUM_W-1:0] diff;
  logic [hnb_pkg::MUL_A_W-1:0]      mag;
  assign diff = $signed({2'b0, acc_q}) - $signed({2'b0, min_q, 16'd0});
  assign mag = diff[hnb_pkg::SUM_W-1] ? hnb_pkg::MUL_A_W'(-diff) : diff[hnb_pkg::MUL_A_W-1:0];

  // Shared multiplier.
  logic [hnb_pkg::MUL_A_W-1:0] mul_a;
  logic [hnb_pkg::MUL_B_W-1:0] mul_b;
  logic [hnb_pkg::MUL_A_W+hnb_pkg::MUL_B_W-1:0] mul_p;
  always_comb begin
    case (state_q)
      hnb_pkg::S_RDA: begin
        mul_a = hnb_pkg::MUL_A_W'(wx);
        mul_b = hnb_pkg::MUL_B_W'(wz);
      end
      hnb_pkg::S_MACB: begin
        mul_a = hnb_pkg::MUL_A_W'(rdata_q);
        mul_b = w_q;
      end
      default: begin
        mul_a = mag;
        mul_b = hnb_pkg::SCALE_360;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Final floor, offset and saturation.
  logic [hnb_pkg::DIV_W-1:0]        q_adj;
  logic signed [hnb_pkg::FIN_W-1:0] fin_val, fin_sat;
  assign q_adj = quo_q + hnb_pkg::DIV_W'(rem_q != '0);
  assign fin_val = (neg_q ? -$signed({2'b0, q_adj}) : $signed({2'b0, quo_q}))
                   - hnb_pkg::HEIGHT_OFFSET;
  assign fin_sat = (fin_val < hnb_pkg::HEIGHT_LOW) ? hnb_pkg::HEIGHT_LOW :
                   (fin_val > hnb_pkg::HEIGHT_HIGH) ? hnb_pkg::HEIGHT_HIGH : fin_val;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hnb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.data.func == hnb_pkg::FUNC_QUERY && max_q > min_q) state_d = hnb_pkg::S_DIVX;
          else state_d = hnb_pkg::S_DONE;
        end
      end
      hnb_pkg::S_DIVX: if (cnt_q == '0) state_d = hnb_pkg::S_LDZ;
      hnb_pkg::S_LDZ:  state_d = hnb_pkg::S_DIVZ;
      hnb_pkg::S_DIVZ: if (cnt_q == '0) state_d = hnb_pkg::S_CAPZ;
      hnb_pkg::S_CAPZ: state_d = hnb_pkg::S_RDA;
      hnb_pkg::S_RDA:  state_d = hnb_pkg::S_MACB;
      hnb_pkg::S_MACB: state_d = (corner_q == 2'd3) ? hnb_pkg::S_NORM : hnb_pkg::S_RDA;
      hnb_pkg::S_NORM: state_d = hnb_pkg::S_DIVN;
      hnb_pkg::S_DIVN: if (cnt_q == '0) state_d = hnb_pkg::S_FIN;
      hnb_pkg::S_FIN:  state_d = hnb_pkg::S_DONE;
      hnb_pkg::S_DONE: if (load_out) state_d = hnb_pkg::S_IDLE;
      default:         state_d = hnb_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready = (state_q == hnb_pkg::S_IDLE);
    load_out = (state_q == hnb_pkg::S_DONE) && (!out_valid_q || out_o.ready);
  end

  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hnb_pkg::S_IDLE;
      res_q       <= hnb_pkg::RES_RESET;
      cell_q      <= hnb_pkg::CELL_RESET;
      min_q       <= hnb_pkg::RAW_MIN_RESET;
      max_q       <= hnb_pkg::RAW_MAX_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          hnb_pkg::REG_RES_LOG2:  res_q <= cfg_i.data[hnb_pkg::RES_W-1:0];
          hnb_pkg::REG_CELL_SIZE: cell_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc && in_i.data.func == hnb_pkg::FUNC_CLEAR) begin
        min_q <= hnb_pkg::RAW_MIN_RESET;
        max_q <= hnb_pkg::RAW_MAX_RESET;
      end else if (mem_we) begin
        if (in_i.data.raw_sample < min_q) min_q <= in_i.data.raw_sample;
        if (in_i.data.raw_sample > max_q) max_q <= in_i.data.raw_sample;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      hnb_pkg::S_IDLE: begin
        res_height_q <= '0;
        if (in_i.data.func == hnb_pkg::FUNC_WRITE && !idx_ok) begin
          res_status_q <= hnb_pkg::STATUS_INDEX;
        end else if (in_i.data.func == hnb_pkg::FUNC_QUERY && max_q <= min_q) begin
          res_status_q <= hnb_pkg::STATUS_RANGE;
        end else begin
          res_status_q <= hnb_pkg::STATUS_OK;
        end
        wz_q     <= in_i.data.world_z;
        quo_q    <= pos_dividend(in_i.data.world_x, half);
        rem_q    <= '0;
        div_q    <= cell_eff;
        cnt_q    <= hnb_pkg::DIV_CNT_W'(hnb_pkg::DIV_W - 1);
        acc_q    <= '0;
        corner_q <= '0;
      end
      hnb_pkg::S_DIVX, hnb_pkg::S_DIVZ, hnb_pkg::S_DIVN: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[hnb_pkg::DIV_W-2:0], qbit};
        cnt_q <= cnt_q - hnb_pkg::DIV_CNT_W'(1);
      end
      hnb_pkg::S_LDZ: begin
        gx_q  <= quo_clamped;
        quo_q <= pos_dividend(wz_q, half);
        rem_q <= '0;
        cnt_q <= hnb_pkg::DIV_CNT_W'(hnb_pkg::DIV_W - 1);
      end
      hnb_pkg::S_CAPZ: gz_q <= quo_clamped;
      hnb_pkg::S_RDA:  w_q <= mul_p[hnb_pkg::MUL_B_W-1:0];
      hnb_pkg::S_MACB: begin
        acc_q    <= acc_q + mul_p[hnb_pkg::ACC_W-1:0];
        corner_q <= corner_q + 2'd1;
      end
      hnb_pkg::S_NORM: begin
        neg_q <= diff[hnb_pkg::SUM_W-1];
        quo_q <= mul_p[hnb_pkg::DIV_W-1:0];
        rem_q <= '0;
        div_q <= max_q - min_q;
        cnt_q <= hnb_pkg::DIV_CNT_W'(hnb_pkg::DIV_W - 1);
      end
      hnb_pkg::S_FIN:  res_height_q <= fin_sat[hnb_pkg::HEIGHT_W-1:0];
      default: ;
    endcase
    if (load_out) begin
      out_data_q.height <= res_height_q;
      out_data_q.status <= res_status_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != hnb_pkg::S_IDLE)
    else $error("accepted item left block idle");
  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hnb_pkg::S_DIVX || state_q == hnb_pkg::S_DIVZ ||
     state_q == hnb_pkg::S_DIVN) |-> rem_q < {1'b0, div_q})
    else $error("divider remainder out of range");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status != hnb_pkg::STATUS_OK) |-> out_data_q.height == '0)
    else $error("failed item carries nonzero height");
  a_fin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hnb_pkg::S_FIN |-> $past(state_q) == hnb_pkg::S_DIVN)
    else $error("final step without normalization divide");
`endif

endmodule

FILE: dv/tb.sv
// Testbench for the heightmap normalize/bilinear sample core: directed table, then random items.
`timescale 1ns / 1ps

module tb;

  localparam int  STORE_N   = 66049;
  localparam longint LIMIT  = 3000000;

  typedef struct {
    hnb_pkg::in_item_t  item;
    bit                 typed;
    hnb_pkg::out_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hnb_in_if  in_ch ();
  hnb_out_if out_ch ();
  hnb_cfg_if cfg_ch ();

  heightmap_normalize_bilinear_sample_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [hnb_pkg::RAW_W-1:0]  heights [STORE_N];
  bit                         written [STORE_N];
  logic [hnb_pkg::RAW_W-1:0]  lo_raw, hi_raw;
  logic [hnb_pkg::RES_W-1:0]  res_reg;
  logic [hnb_pkg::CELL_W-1:0] cell_reg;

  hnb_pkg::out_item_t pending_q[$];
  int        errors = 0;
  longint    cycles = 0;
  int        burst_left = 0;

  function automatic int grid_last();
    int r;
    r = int'(res_reg);
    if (r < 4) r = 4;
    if (r > 8) r = 8;
    return 1 << r;
  endfunction

  function automatic int eff_cell();
    return (cell_reg == 0) ? 1 : int'(cell_reg);
  endfunction

  function automatic longint to_grid(longint w, int last, int cell_sz);
    longint half, num, g;
    half = (longint'(last) * cell_sz) / 2;
    num = (w + half) * 256;
    if (num < 0) return 0;
    g = num / cell_sz;
    if (g > longint'(last) * 256) g = longint'(last) * 256;
    return g;
  endfunction

  // corner indices h00, h10, h01, h11 and fractions of a query
  task automatic corners(input hnb_pkg::in_item_t it, output int idx[4], output int tx,
                         output int tz);
    int last, side, x0, z0, x1, z1;
    longint gx, gz;
    last = grid_last();
    side = last + 1;
    gx = to_grid(longint'(it.world_x), last, eff_cell());
    gz = to_grid(longint'(it.world_z), last, eff_cell());
    x0 = int'(gx >> 8);
    z0 = int'(gz >> 8);
    tx = int'(gx & 255);
    tz = int'(gz & 255);
    x1 = (x0 + 1 > last) ? last : x0 + 1;
    z1 = (z0 + 1 > last) ? last : z0 + 1;
    idx[0] = z0 * side + x0;
    idx[1] = z0 * side + x1;
    idx[2] = z1 * side + x0;
    idx[3] = z1 * side + x1;
  endtask

  task automatic apply_item(input hnb_pkg::in_item_t it, output hnb_pkg::out_item_t res);
    int idx[4];
    int tx, tz, side;
    longint a, b, v, num, rng, q;
    res = '0;
    side = grid_last() + 1;
    case (it.func)
      hnb_pkg::FUNC_CLEAR: begin
        lo_raw = hnb_pkg::RAW_MIN_RESET;
        hi_raw = hnb_pkg::RAW_MAX_RESET;
      end
      hnb_pkg::FUNC_WRITE: begin
        if (int'(it.sample_index) < side * side) begin
          heights[it.sample_index] = it.raw_sample;
          written[it.sample_index] = 1'b1;
          if (it.raw_sample < lo_raw) lo_raw = it.raw_sample;
          if (it.raw_sample > hi_raw) hi_raw = it.raw_sample;
        end else begin
          res.status = hnb_pkg::STATUS_INDEX;
        end
      end
      hnb_pkg::FUNC_QUERY: begin
        if (hi_raw <= lo_raw) begin
          res.status = hnb_pkg::STATUS_RANGE;
        end else begin
          corners(it, idx, tx, tz);
          a = longint'(heights[idx[0]]) * (256 - tx) + longint'(heights[idx[1]]) * tx;
          b = longint'(heights[idx[2]]) * (256 - tx) + longint'(heights[idx[3]]) * tx;
          v = a * (256 - tz) + b * tz;
          num = (v - longint'(lo_raw) * 65536) * 360;
          rng = longint'(hi_raw) - longint'(lo_raw);
          q = num / rng;
          if ((num % rng) != 0 && num < 0) q = q - 1;
          q = q - 5898240;
          if (q < -5898240) q = -5898240;
          if (q > 17694720) q = 17694720;
          res.height = q[hnb_pkg::HEIGHT_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  task automatic drive(input hnb_pkg::in_item_t it, input bit typed,
                       input hnb_pkg::out_item_t want);
    hnb_pkg::out_item_t res;
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    apply_item(it, res);
    pending_q.push_back(typed ? want : res);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // every store entry a query reads is written first
  task automatic send(input hnb_pkg::in_item_t it, input bit typed = 0,
                      input hnb_pkg::out_item_t want = '0);
    int idx[4];
    int tx, tz;
    hnb_pkg::in_item_t wr;
    if (it.func == hnb_pkg::FUNC_QUERY && hi_raw > lo_raw) begin
      corners(it, idx, tx, tz);
      foreach (idx[k]) begin
        if (!written[idx[k]]) begin
          wr = '0;
          wr.func = hnb_pkg::FUNC_WRITE;
          wr.sample_index = hnb_pkg::INDEX_W'(idx[k]);
          wr.raw_sample = hnb_pkg::RAW_W'($urandom());
          drive(wr, 0, '0);
        end
      end
    end
    drive(it, typed, want);
  endtask

  task automatic cfg_write(input logic [hnb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hnb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == hnb_pkg::REG_RES_LOG2) res_reg = val[hnb_pkg::RES_W-1:0];
    else if (idx == hnb_pkg::REG_CELL_SIZE) cell_reg = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic hnb_pkg::in_item_t rand_item();
    hnb_pkg::in_item_t it;
    int pick, last;
    longint g, half, w;
    it = '0;
    it.sample_index = hnb_pkg::INDEX_W'($urandom());
    it.raw_sample = hnb_pkg::RAW_W'($urandom());
    it.world_x = $urandom();
    it.world_z = $urandom();
    pick = $urandom_range(0, 99);
    last = grid_last();
    if (pick < 6) it.func = hnb_pkg::FUNC_CLEAR;
    else if (pick < 9) it.func = hnb_pkg::FUNC_UNUSED;
    else if (pick < 42) begin
      it.func = hnb_pkg::FUNC_WRITE;
      if ($urandom_range(0, 9) != 0)
        it.sample_index = hnb_pkg::INDEX_W'($urandom_range(0, (last + 1) * (last + 1) - 1));
    end else begin
      it.func = hnb_pkg::FUNC_QUERY;
      if ($urandom_range(0, 4) != 0) begin
        half = (longint'(last) * eff_cell()) / 2;
        g = $urandom_range(0, last * 256);
        w = g * eff_cell() / 256 - half + $urandom_range(0, 16) - 8;
        it.world_x = w[hnb_pkg::WORLD_W-1:0];
        g = $urandom_range(0, last * 256);
        w = g * eff_cell() / 256 - half + $urandom_range(0, 16) - 8;
        it.world_z = w[hnb_pkg::WORLD_W-1:0];
      end
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: height %0d status %0d",
                 $time, out_ch.data.height, out_ch.data.status);
        errors++;
      end else begin
        if (out_ch.data.height !== pending_q[0].height) begin
          $display("%0t: height expected %0d actual %0d",
                   $time, pending_q[0].height, out_ch.data.height);
          errors++;
        end
        if (out_ch.data.status !== pending_q[0].status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, pending_q[0].status, out_ch.data.status);
          errors++;
        end
        void'(pending_q.pop_front());
      end
    end
  end

  // receiver stalls: modes change at random among always ready, random ready and a fixed pattern
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= (stall_cnt % 7) > 2;
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic [hnb_pkg::FUNC_W-1:0] f, int idx, int raw, int wx,
                                    int wz, bit typed = 0, int h = 0,
                                    logic [hnb_pkg::STATUS_W-1:0] st = hnb_pkg::STATUS_OK);
    stim_row_t r;
    r.item.func = f;
    r.item.sample_index = hnb_pkg::INDEX_W'(idx);
    r.item.raw_sample = hnb_pkg::RAW_W'(raw);
    r.item.world_x = wx;
    r.item.world_z = wz;
    r.typed = typed;
    r.want.height = hnb_pkg::HEIGHT_W'(h);
    r.want.status = st;
    return r;
  endfunction

  int res_set[7]  = '{8, 4, 4, 15, 0, 6, 8};
  int cell_set[7] = '{512, 1, 65535, 0, 256, 1000, 65535};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    foreach (heights[k]) begin
      heights[k] = '0;
      written[k] = 1'b0;
    end
    lo_raw = hnb_pkg::RAW_MIN_RESET;
    hi_raw = hnb_pkg::RAW_MAX_RESET;
    res_reg = hnb_pkg::RES_RESET;
    cell_reg = hnb_pkg::CELL_RESET;

    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 0, hnb_pkg::STATUS_RANGE));
    dir_rows.push_back(row(hnb_pkg::FUNC_CLEAR, 0, 0, 0, 0, 1, 0, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 131071, 5, 0, 0, 1, 0, hnb_pkg::STATUS_INDEX));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 66049, 5, 0, 0, 1, 0, hnb_pkg::STATUS_INDEX));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 0, 0, 0, 0, 1, 0, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 1, 65535, 0, 0, 1, 0, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 257, 65535, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 258, 0, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 66048, 40000, 0, 0, 1, 0, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_UNUSED, 5, 5, 5, 5, 1, 0, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, 32'h8000_0000, 32'h8000_0000,
                           1, -5898240, hnb_pkg::STATUS_OK));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, -65536 + 128, -65536 + 255));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 131071, 65535, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_CLEAR, 0, 0, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 1, 30000, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, -65536, -65536, 1, 0,
                           hnb_pkg::STATUS_RANGE));
    dir_rows.push_back(row(hnb_pkg::FUNC_WRITE, 257, 30001, 0, 0));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, -65536 + 128, -65536 + 128));
    dir_rows.push_back(row(hnb_pkg::FUNC_QUERY, 0, 0, -65536, -65536));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) send(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    go_idle();

    foreach (res_set[p]) begin
      cfg_write(hnb_pkg::REG_RES_LOG2, hnb_pkg::CFG_DATA_W'(res_set[p]));
      cfg_write(hnb_pkg::REG_CELL_SIZE, hnb_pkg::CFG_DATA_W'(cell_set[p]));
      repeat (70) send(rand_item());
      go_idle();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/hnb_pkg.sv
hw/rtl/hnb_in_if.sv
hw/rtl/hnb_out_if.sv
hw/rtl/hnb_cfg_if.sv
hw/rtl/heightmap_normalize_bilinear_sample_core.sv
dv/tb.sv
